// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the ALU block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset cycles included.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/c8alu_pkg.sv =====
// Shared types and constants of the 8-bit ALU pipeline.
`timescale 1ns / 1ps

package c8alu_pkg;

    typedef enum logic [4:0] {
        ACT_ADD   = 5'd0,
        ACT_ADC   = 5'd1,
        ACT_SUB   = 5'd2,
        ACT_SBC   = 5'd3,
        ACT_AND   = 5'd4,
        ACT_XOR   = 5'd5,
        ACT_OR    = 5'd6,
        ACT_CP    = 5'd7,
        ACT_INC   = 5'd8,
        ACT_DEC   = 5'd9,
        ACT_DAA   = 5'd10,
        ACT_NEG   = 5'd11,
        ACT_RLC   = 5'd12,
        ACT_RRC   = 5'd13,
        ACT_RL    = 5'd14,
        ACT_RR    = 5'd15,
        ACT_SLA   = 5'd16,
        ACT_SRA   = 5'd17,
        ACT_SLL   = 5'd18,
        ACT_SRL   = 5'd19,
        ACT_ADD16 = 5'd20,
        ACT_ADC16 = 5'd21,
        ACT_SBC16 = 5'd22
    } t_action;

    // Operation class carried down the pipe; selects result and flag rules.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ARITH8,
        OP_CP,
        OP_INCDEC,
        OP_DAA,
        OP_LOGIC,
        OP_SHIFT,
        OP_ADD16,
        OP_ARITH16
    } t_op;

    typedef enum logic [1:0] {
        LG_AND,
        LG_XOR,
        LG_OR
    } t_logic;

    typedef enum logic [2:0] {
        SH_RLC = 3'd0,
        SH_RRC = 3'd1,
        SH_RL  = 3'd2,
        SH_RR  = 3'd3,
        SH_SLA = 3'd4,
        SH_SRA = 3'd5,
        SH_SLL = 3'd6,
        SH_SRL = 3'd7
    } t_shift;

    localparam logic [4:0] SHIFT_BASE   = 5'd12;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
    localparam logic [7:0] DAA_ADJ_HI   = 8'h60;
    localparam logic [7:0] DAA_ADJ_LO   = 8'h06;

    // Decode stage to execute stage.
    typedef struct packed {
        t_op         op;
        t_logic      lsel;
        t_shift      skind;
        logic [15:0] x;
        logic [15:0] y;
        logic        cin;
        logic        sub;
        logic [7:0]  v8;
        logic [7:0]  fin;
        logic        daa_cy;
    } t_s1;

    // Execute stage to flag stage.
    typedef struct packed {
        t_op         op;
        logic        sub;
        logic [7:0]  v8;
        logic [7:0]  fin;
        logic        daa_cy;
        logic [15:0] res;
        logic [16:0] cv;
        logic        co;
        logic        lh;
    } t_s2;

endpackage

// ===== rtl/core/c8alu_decode.sv =====
// Stage 1: decode the action and set up adder operands.
`timescale 1ns / 1ps

module c8alu_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [4:0]       i_action,
    input  logic [15:0]      i_left_operand,
    input  logic [15:0]      i_right_operand,
    input  logic [7:0]       i_flags_in,
    output logic             o_valid,
    output c8alu_pkg::t_s1   o_s1
);
    import c8alu_pkg::*;

    logic        r_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [7:0]  a;
    logic [7:0]  v;
    logic        cin;
    logic        sb;
    logic        hf;
    logic        adj_hi;
    logic        adj_lo;
    logic [7:0]  adj;
    logic [4:0]  shift_off;

    assign a         = i_left_operand[7:0];
    assign v         = i_right_operand[7:0];
    assign cin       = i_flags_in[0];
    assign sb        = i_flags_in[1];
    assign hf        = i_flags_in[4];
    assign shift_off = i_action - SHIFT_BASE;

    // Decimal adjust: after a subtract only the stored carries pick the correction.
    assign adj_hi = cin | (!sb && (a > DAA_HI_LIMIT));
    assign adj_lo = hf | (!sb && (a[3:0] > DAA_LO_LIMIT));
    assign adj    = (adj_hi ? DAA_ADJ_HI : 8'h00) | (adj_lo ? DAA_ADJ_LO : 8'h00);

    always_comb begin
        n_s1        = '0;
        n_s1.op     = OP_NONE;
        n_s1.lsel   = LG_AND;
        n_s1.skind  = t_shift'(shift_off[2:0]);
        n_s1.v8     = v;
        n_s1.fin    = i_flags_in;
        n_s1.daa_cy = adj_hi;
        case (t_action'(i_action))
            ACT_ADD, ACT_ADC: begin
                n_s1.op  = OP_ARITH8;
                n_s1.x   = {8'h00, a};
                n_s1.y   = {8'h00, v};
                n_s1.cin = (t_action'(i_action) == ACT_ADC) ? cin : 1'b0;
            end
            ACT_SUB, ACT_SBC, ACT_CP: begin
                n_s1.op  = (t_action'(i_action) == ACT_CP) ? OP_CP : OP_ARITH8;
                n_s1.x   = {8'h00, a};
                n_s1.y   = {8'h00, ~v};
                n_s1.cin = (t_action'(i_action) == ACT_SBC) ? !cin : 1'b1;
                n_s1.sub = 1'b1;
            end
            ACT_AND: begin
                n_s1.op   = OP_LOGIC;
                n_s1.lsel = LG_AND;
                n_s1.x    = {8'h00, a};
                n_s1.y    = {8'h00, v};
            end
            ACT_XOR: begin
                n_s1.op   = OP_LOGIC;
                n_s1.lsel = LG_XOR;
                n_s1.x    = {8'h00, a};
                n_s1.y    = {8'h00, v};
            end
            ACT_OR: begin
                n_s1.op   = OP_LOGIC;
                n_s1.lsel = LG_OR;
                n_s1.x    = {8'h00, a};
                n_s1.y    = {8'h00, v};
            end
            ACT_INC: begin
                n_s1.op  = OP_INCDEC;
                n_s1.x   = {8'h00, v};
                n_s1.cin = 1'b1;
            end
            ACT_DEC: begin
                n_s1.op  = OP_INCDEC;
                n_s1.x   = {8'h00, v};
                n_s1.y   = 16'h00FF;
                n_s1.sub = 1'b1;
            end
            ACT_DAA: begin
                n_s1.op  = OP_DAA;
                n_s1.x   = {8'h00, a};
                n_s1.y   = sb ? {8'h00, ~adj} : {8'h00, adj};
                n_s1.cin = sb;
                n_s1.sub = sb;
            end
            ACT_NEG: begin
                n_s1.op  = OP_ARITH8;
                n_s1.y   = {8'h00, ~a};
                n_s1.cin = 1'b1;
                n_s1.sub = 1'b1;
            end
            ACT_RLC, ACT_RRC, ACT_RL, ACT_RR,
            ACT_SLA, ACT_SRA, ACT_SLL, ACT_SRL: begin
                n_s1.op = OP_SHIFT;
            end
            ACT_ADD16, ACT_ADC16: begin
                n_s1.op  = (t_action'(i_action) == ACT_ADD16) ? OP_ADD16 : OP_ARITH16;
                n_s1.x   = i_left_operand;
                n_s1.y   = i_right_operand;
                n_s1.cin = (t_action'(i_action) == ACT_ADC16) ? cin : 1'b0;
            end
            ACT_SBC16: begin
                n_s1.op  = OP_ARITH16;
                n_s1.x   = i_left_operand;
                n_s1.y   = ~i_right_operand;
                n_s1.cin = !cin;
                n_s1.sub = 1'b1;
            end
            default: begin
                n_s1.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ===== rtl/core/c8alu_exec.sv =====
// Stage 2: shared 16-bit adder, logic unit and shifter.
`timescale 1ns / 1ps

module c8alu_exec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  c8alu_pkg::t_s1   i_s1,
    output logic             o_valid,
    output c8alu_pkg::t_s2   o_s2
);
    import c8alu_pkg::*;

    logic        r_valid;
    t_s2         r_s2;
    t_s2         n_s2;
    logic [16:0] sum;
    logic [7:0]  lres;
    logic [7:0]  sres;
    logic        sco;
    logic [7:0]  v;
    logic        cf;

    assign v  = i_s1.v8;
    assign cf = i_s1.fin[0];

    assign sum = {1'b0, i_s1.x} + {1'b0, i_s1.y} + {16'h0000, i_s1.cin};

    always_comb begin
        case (i_s1.lsel)
            LG_AND:  lres = i_s1.x[7:0] & i_s1.y[7:0];
            LG_XOR:  lres = i_s1.x[7:0] ^ i_s1.y[7:0];
            LG_OR:   lres = i_s1.x[7:0] | i_s1.y[7:0];
            default: lres = 8'h00;
        endcase
    end

    always_comb begin
        case (i_s1.skind)
            SH_RLC:  begin sco = v[7]; sres = {v[6:0], v[7]}; end
            SH_RRC:  begin sco = v[0]; sres = {v[0], v[7:1]}; end
            SH_RL:   begin sco = v[7]; sres = {v[6:0], cf}; end
            SH_RR:   begin sco = v[0]; sres = {cf, v[7:1]}; end
            SH_SLA:  begin sco = v[7]; sres = {v[6:0], 1'b0}; end
            SH_SRA:  begin sco = v[0]; sres = {v[7], v[7:1]}; end
            SH_SLL:  begin sco = v[7]; sres = {v[6:0], 1'b1}; end
            SH_SRL:  begin sco = v[0]; sres = {1'b0, v[7:1]}; end
            default: begin sco = 1'b0; sres = 8'h00; end
        endcase
    end

    always_comb begin
        n_s2        = '0;
        n_s2.op     = i_s1.op;
        n_s2.sub    = i_s1.sub;
        n_s2.v8     = i_s1.v8;
        n_s2.fin    = i_s1.fin;
        n_s2.daa_cy = i_s1.daa_cy;
        // Carry into each bit position of the sum.
        n_s2.cv     = sum ^ {1'b0, i_s1.x} ^ {1'b0, i_s1.y};
        n_s2.co     = sco;
        n_s2.lh     = (i_s1.lsel == LG_AND);
        case (i_s1.op)
            OP_LOGIC:              n_s2.res = {8'h00, lres};
            OP_SHIFT:              n_s2.res = {8'h00, sres};
            OP_ADD16, OP_ARITH16:  n_s2.res = sum[15:0];
            OP_NONE:               n_s2.res = 16'h0000;
            default:               n_s2.res = {8'h00, sum[7:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

// ===== rtl/core/c8alu_flags.sv =====
// Stage 3: flag byte assembly and the output register.
`timescale 1ns / 1ps

module c8alu_flags (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  c8alu_pkg::t_s2   i_s2,
    output logic             o_valid,
    output logic [15:0]      o_result,
    output logic [7:0]       o_flags,
    output logic             o_write
);
    import c8alu_pkg::*;

    logic        r_valid;
    logic [15:0] r_result;
    logic [7:0]  r_flags;
    logic        r_write;
    logic [7:0]  n_flags;
    logic        n_write;
    logic [7:0]  r8;
    logic [7:0]  fin;
    logic        z8;
    logic        z16;
    logic        par;
    logic        h8;
    logic        c8;
    logic        ov8;
    logic        h16;
    logic        c16;
    logic        ov16;

    assign r8   = i_s2.res[7:0];
    assign fin  = i_s2.fin;
    assign z8   = (r8 == 8'h00);
    assign z16  = (i_s2.res == 16'h0000);
    assign par  = ~^r8;
    // On a subtract the adder carries are inverted borrows.
    assign h8   = i_s2.cv[4] ^ i_s2.sub;
    assign c8   = i_s2.cv[8] ^ i_s2.sub;
    assign ov8  = i_s2.cv[7] ^ i_s2.cv[8];
    assign h16  = i_s2.cv[12] ^ i_s2.sub;
    assign c16  = i_s2.cv[16] ^ i_s2.sub;
    assign ov16 = i_s2.cv[15] ^ i_s2.cv[16];

    always_comb begin
        n_write = 1'b1;
        case (i_s2.op)
            OP_ARITH8:  n_flags = {r8[7], z8, r8[5], h8, r8[3], ov8, i_s2.sub, c8};
            OP_CP: begin
                n_flags = {r8[7], z8, i_s2.v8[5], h8, i_s2.v8[3], ov8, 1'b1, c8};
                n_write = 1'b0;
            end
            OP_INCDEC:  n_flags = {r8[7], z8, r8[5], h8, r8[3], ov8, i_s2.sub, fin[0]};
            OP_DAA:     n_flags = {r8[7], z8, r8[5], h8, r8[3], par, fin[1], i_s2.daa_cy};
            OP_LOGIC:   n_flags = {r8[7], z8, r8[5], i_s2.lh, r8[3], par, 2'b00};
            OP_SHIFT:   n_flags = {fin[7:1], i_s2.co};
            OP_ADD16:   n_flags = {fin[7:5], h16, fin[3:2], 1'b0, c16};
            OP_ARITH16: n_flags = {i_s2.res[15], z16, fin[5], h16, fin[3], ov16,
                                   i_s2.sub, c16};
            default: begin
                n_flags = fin;
                n_write = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= i_s2.res;
            r_flags  <= n_flags;
            r_write  <= n_write;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_flags  = r_flags;
    assign o_write  = r_write;

endmodule

// ===== rtl/core/cpu8_alu_with_flags_top.sv =====
// 8-bit CPU ALU with flag byte: three-stage pipeline (decode, execute, flags).
// Items pass the decode, execute (17-bit adder, the deepest path) and flag registers in turn.
// Throughput: one transfer per cycle while the output is not stalled.
// Each stage advances when the stage after it is empty or advancing, so bubbles collapse.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpu8_alu_with_flags_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [4:0]  i_action,
    input  logic [15:0] i_left_operand,
    input  logic [15:0] i_right_operand,
    input  logic [7:0]  i_flags_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_result,
    output logic [7:0]  o_flags_out,
    output logic        o_write_result
);
    import c8alu_pkg::*;

    logic s1_valid;
    logic s2_valid;
    t_s1  s1;
    t_s2  s2;
    logic en1;
    logic en2;
    logic en3;

    // Stage enables: the output stage loads when empty or when its result transfers;
    // every earlier stage loads when its successor is empty or loading.
    assign en3 = !o_out_valid || i_out_ready;
    assign en2 = !s2_valid || en3;
    assign en1 = !s1_valid || en2;

    // Take a new item whenever the decode register is free or about to move on.
    assign o_in_ready = en1;

    // Decode: classify the action, select and invert operands, form the DAA correction.
    c8alu_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en1),
        .i_valid         (i_in_valid),
        .i_action        (i_action),
        .i_left_operand  (i_left_operand),
        .i_right_operand (i_right_operand),
        .i_flags_in      (i_flags_in),
        .o_valid         (s1_valid),
        .o_s1            (s1)
    );

    // Execute: one 17-bit adder shared by all arithmetic, plus logic and shift units.
    c8alu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    // Flags: zero, parity, half carry, overflow and carry into the flag byte;
    // hold the result in the output register until it transfers.
    c8alu_flags u_flags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en3),
        .i_valid  (s2_valid),
        .i_s2     (s2),
        .o_valid  (o_out_valid),
        .o_result (o_result),
        .o_flags  (o_flags_out),
        .o_write  (o_write_result)
    );

    `ASSERT_RST(a_rst_empties, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `ASSERT_CLK(a_ready_flows, i_out_ready |-> o_in_ready, "input stalled with free output")
    `ASSERT_CLK(a_cp_no_write, s2_valid && s2.op == OP_CP && en3 |=> !o_write_result, "compare writes")
    `ASSERT_CLK(a_shift_keeps, s2_valid && s2.op == OP_SHIFT && en3 |=> o_flags_out[7:1] == $past(s2.fin[7:1]), "shift changed flags")
    `ASSERT_CLK(a_unused_zero, s2_valid && s2.op == OP_NONE && en3 |=> o_result == 16'h0000 && !o_write_result, "unused action output")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pipelined 8-bit CPU ALU with flag byte.
`timescale 1ns / 1ps

module tb;
    import c8alu_pkg::*;

    // Flag byte layout: S Z F5 H F3 PV N C
    localparam logic [7:0] FL_S  = 8'h80;
    localparam logic [7:0] FL_Z  = 8'h40;
    localparam logic [7:0] FL_F5 = 8'h20;
    localparam logic [7:0] FL_H  = 8'h10;
    localparam logic [7:0] FL_F3 = 8'h08;
    localparam logic [7:0] FL_PV = 8'h04;
    localparam logic [7:0] FL_N  = 8'h02;
    localparam logic [7:0] FL_C  = 8'h01;
    localparam logic [7:0] FL_53 = FL_F5 | FL_F3;

    // First action code past the defined set; everything from here to 31 is unused.
    localparam logic [4:0] ACT_UNUSED_LO = 5'd23;
    localparam logic [4:0] ACT_UNUSED_HI = 5'd31;

    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;

    // One expected ALU transfer, tagged with the action that produced it.
    typedef struct packed {
        logic [4:0]  act;
        logic [15:0] res;
        logic [7:0]  flags;
        logic        wr;
    } t_alu_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [4:0]  in_action = '0;
    logic [15:0] in_left = '0;
    logic [15:0] in_right = '0;
    logic [7:0]  in_flags = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_result;
    logic [7:0]  out_flags;
    logic        out_write;

    t_alu_out pending_results[$];
    t_alu_out head;
    int       fail_count = 0;
    int       sink_hold = 0;
    bit       src_idle_on = 1'b0;
    bit       sink_idle_on = 1'b0;

    cpu8_alu_with_flags_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (in_action),
        .i_left_operand  (in_left),
        .i_right_operand (in_right),
        .i_flags_in      (in_flags),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_result        (out_result),
        .o_flags_out     (out_flags),
        .o_write_result  (out_write)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // ALU predictor
    // ------------------------------------------------------------------

    // Sign, zero and the two undocumented copy bits of an 8-bit value.
    function automatic logic [7:0] sz53(input logic [7:0] r);
        return {r[7], r == 8'h00, r[5], 1'b0, r[3], 3'b000};
    endfunction

    function automatic logic [7:0] parity_pv(input logic [7:0] r);
        return (~^r) ? FL_PV : 8'h00;
    endfunction

    function automatic logic [7:0] add_byte(input logic [7:0] a, input logic [7:0] v,
                                            input logic c, output logic [7:0] f);
        logic [8:0] sum;
        logic [4:0] half;
        sum  = a + v + c;
        half = a[3:0] + v[3:0] + c;
        f = sz53(sum[7:0]);
        if (half[4]) f |= FL_H;
        if ((a[7] ^ sum[7]) & (v[7] ^ sum[7])) f |= FL_PV;
        if (sum[8]) f |= FL_C;
        return sum[7:0];
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] a, input logic [7:0] v,
                                            input logic c, output logic [7:0] f);
        logic [8:0] take;
        logic [4:0] take_lo;
        logic [7:0] r;
        take    = v + c;
        take_lo = v[3:0] + c;
        r       = a - v - {7'd0, c};
        f = sz53(r) | FL_N;
        if ({1'b0, a[3:0]} < take_lo) f |= FL_H;
        if ((a[7] ^ v[7]) & (a[7] ^ r[7])) f |= FL_PV;
        if ({1'b0, a} < take) f |= FL_C;
        return r;
    endfunction

    // Compute result, flag byte and write enable for one ALU transfer.
    function automatic t_alu_out alu_eval(input logic [4:0] act, input logic [15:0] lft,
                                          input logic [15:0] rgt, input logic [7:0] fin);
        t_alu_out   o;
        logic [7:0] a, v, r8, fl, adj;
        logic       cin, co, cy, is_shift;
        logic [16:0] s17, t17;
        logic [12:0] h13;
        logic [4:0]  lo5;
        a   = lft[7:0];
        v   = rgt[7:0];
        cin = fin[0];
        r8  = 8'h00;
        fl  = fin;
        co  = 1'b0;
        is_shift = 1'b0;
        o.act = act;
        o.res = 16'h0000;
        o.wr  = 1'b1;
        case (act)
            ACT_ADD: r8 = add_byte(a, v, 1'b0, fl);
            ACT_ADC: r8 = add_byte(a, v, cin, fl);
            ACT_SUB: r8 = sub_byte(a, v, 1'b0, fl);
            ACT_SBC: r8 = sub_byte(a, v, cin, fl);
            ACT_AND: begin
                r8 = a & v;
                fl = sz53(r8) | parity_pv(r8) | FL_H;
            end
            ACT_XOR: begin
                r8 = a ^ v;
                fl = sz53(r8) | parity_pv(r8);
            end
            ACT_OR: begin
                r8 = a | v;
                fl = sz53(r8) | parity_pv(r8);
            end
            ACT_CP: begin
                // copy bits come from the operand, not the difference
                r8 = sub_byte(a, v, 1'b0, fl);
                fl = (fl & ~FL_53) | (v & FL_53);
                o.wr = 1'b0;
            end
            ACT_INC: begin
                r8 = v + 8'h01;
                fl = sz53(r8) | {7'd0, cin};
                if (v[3:0] == 4'hF) fl |= FL_H;
                if (v == 8'h7F) fl |= FL_PV;
            end
            ACT_DEC: begin
                r8 = v - 8'h01;
                fl = sz53(r8) | {7'd0, cin} | FL_N;
                if (v[3:0] == 4'h0) fl |= FL_H;
                if (v == 8'h80) fl |= FL_PV;
            end
            ACT_DAA: begin
                adj = 8'h00;
                cy  = cin;
                if (fin[1]) begin
                    if (cy) adj |= DAA_ADJ_HI;
                    if (fin[4]) adj |= DAA_ADJ_LO;
                    r8 = a - adj;
                    fl = (fin[4] && a[3:0] < 4'd6) ? FL_H : 8'h00;
                end else begin
                    if (cy || a > DAA_HI_LIMIT) begin
                        adj |= DAA_ADJ_HI;
                        cy = 1'b1;
                    end
                    if (fin[4] || a[3:0] > DAA_LO_LIMIT) adj |= DAA_ADJ_LO;
                    r8  = a + adj;
                    lo5 = a[3:0] + adj[3:0];
                    fl  = lo5[4] ? FL_H : 8'h00;
                end
                fl |= sz53(r8) | parity_pv(r8) | (fin & FL_N) | {7'd0, cy};
            end
            ACT_NEG: r8 = sub_byte(8'h00, a, 1'b0, fl);
            ACT_RLC: begin co = v[7]; r8 = {v[6:0], v[7]}; is_shift = 1'b1; end
            ACT_RRC: begin co = v[0]; r8 = {v[0], v[7:1]}; is_shift = 1'b1; end
            ACT_RL:  begin co = v[7]; r8 = {v[6:0], cin};  is_shift = 1'b1; end
            ACT_RR:  begin co = v[0]; r8 = {cin, v[7:1]};  is_shift = 1'b1; end
            ACT_SLA: begin co = v[7]; r8 = {v[6:0], 1'b0}; is_shift = 1'b1; end
            ACT_SRA: begin co = v[0]; r8 = {v[7], v[7:1]}; is_shift = 1'b1; end
            ACT_SLL: begin co = v[7]; r8 = {v[6:0], 1'b1}; is_shift = 1'b1; end
            ACT_SRL: begin co = v[0]; r8 = {1'b0, v[7:1]}; is_shift = 1'b1; end
            ACT_ADD16: begin
                s17 = lft + rgt;
                h13 = lft[11:0] + rgt[11:0];
                o.res = s17[15:0];
                fl = fin & ~(FL_C | FL_H | FL_N);
                if (s17[16]) fl |= FL_C;
                if (h13[12]) fl |= FL_H;
            end
            ACT_ADC16: begin
                s17 = lft + rgt + cin;
                h13 = lft[11:0] + rgt[11:0] + cin;
                o.res = s17[15:0];
                fl = fin & FL_53;
                if (o.res[15]) fl |= FL_S;
                if (o.res == 16'h0000) fl |= FL_Z;
                if (h13[12]) fl |= FL_H;
                if ((lft[15] ^ o.res[15]) & (rgt[15] ^ o.res[15])) fl |= FL_PV;
                if (s17[16]) fl |= FL_C;
            end
            ACT_SBC16: begin
                t17 = rgt + cin;
                h13 = rgt[11:0] + cin;
                o.res = lft - rgt - {15'd0, cin};
                fl = (fin & FL_53) | FL_N;
                if (o.res[15]) fl |= FL_S;
                if (o.res == 16'h0000) fl |= FL_Z;
                if ({1'b0, lft[11:0]} < h13) fl |= FL_H;
                if ((lft[15] ^ rgt[15]) & (lft[15] ^ o.res[15])) fl |= FL_PV;
                if ({1'b0, lft} < t17) fl |= FL_C;
            end
            default: begin
                fl   = fin;
                o.wr = 1'b0;
            end
        endcase
        if (is_shift) fl = {fin[7:1], co};
        if (act < ACT_ADD16) o.res = {8'h00, r8};
        o.flags = fl;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver and result checker
    // ------------------------------------------------------------------

    // Offer one operation, hold it until the transfer, then log its prediction.
    task automatic send_op(input logic [4:0] act, input logic [15:0] lft,
                           input logic [15:0] rgt, input logic [7:0] fin);
        // insert random bubbles before raising valid
        while (src_idle_on && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_left   <= lft;
        in_right  <= rgt;
        in_flags  <= fin;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pending_results = {pending_results, alu_eval(act, lft, rgt, fin)};
    endtask

    // Operand with a bias toward carry, overflow and zero corners.
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(11))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w = 16'h8000;
            3: w = 16'h7FFF;
            4: w[7:0] = 8'h7F;
            5: w[7:0] = 8'h80;
            6: w[11:0] = 12'hFFF;
            7: w[7:0] = 8'h00;
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_random_ops(input int count);
        logic [4:0] act;
        repeat (count) begin
            // mostly defined actions, a few from the unused code range
            if ($urandom_range(99) < 6)
                act = 5'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
            else
                act = 5'($urandom_range(ACT_SBC16));
            send_op(act, pick_word(), pick_word(), 8'($urandom));
        end
    endtask

    // Park the sender until every predicted transfer has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Receiver: count down a requested hold, otherwise stall at random.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            out_ready <= 1'b0;
            sink_hold--;
        end else if (sink_idle_on && $urandom_range(99) < 10) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                log_failure($sformatf("unexpected result res=%h flags=%h wr=%b",
                                      out_result, out_flags, out_write));
            end else begin
                head = pending_results.pop_front();
                if (out_result !== head.res || out_flags !== head.flags
                        || out_write !== head.wr)
                    log_failure($sformatf(
                        "action %0d: exp res=%h flags=%h wr=%b, got res=%h flags=%h wr=%b",
                        head.act, head.res, head.flags, head.wr,
                        out_result, out_flags, out_write));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Byte arithmetic, logic, compare, inc/dec, decimal adjust and negate at their corners.
    task automatic test_byte_ops();
        send_op(ACT_ADD, 16'h12FF, 16'h3401, 8'h00);   // wrap to zero: Z, H, C
        send_op(ACT_ADC, 16'h007F, 16'hFF00, FL_C);    // signed overflow through carry in
        send_op(ACT_SUB, 16'h0000, 16'h0001, 8'hFF);   // borrow from zero
        send_op(ACT_SBC, 16'h0080, 16'h0000, FL_C);    // overflow on borrow
        send_op(ACT_AND, 16'h00F0, 16'h000F, 8'hFF);
        send_op(ACT_XOR, 16'hFFFF, 16'hFFFF, 8'h00);
        send_op(ACT_OR,  16'h0080, 16'h0001, 8'h00);
        // compare: copy bits follow the operand, no write
        send_op(ACT_CP,  16'h0010, 16'h0028, 8'h00);
        send_op(ACT_INC, 16'h0000, 16'h007F, FL_C);    // carry kept, overflow
        send_op(ACT_INC, 16'h0000, 16'h00FF, 8'h00);
        send_op(ACT_DEC, 16'h0000, 16'h0080, FL_C);
        send_op(ACT_DAA, 16'h009A, 16'h0000, 8'h00);   // add side, both nibbles adjust
        send_op(ACT_DAA, 16'h0000, 16'h0000, FL_N | FL_H | FL_C);
        send_op(ACT_NEG, 16'h0080, 16'h0000, 8'h00);
    endtask

    // All eight shift forms, the word ops and one code from the unused range.
    task automatic test_shift_word_ops();
        logic [4:0] act;
        for (int k = 0; k < 8; k++) begin
            act = ACT_RLC + 5'(k);
            // alternate incoming flags so every kept bit shows both values
            send_op(act, 16'h0000, 16'h0081, k[0] ? FL_C : 8'hFE);
        end
        send_op(ACT_ADD16, 16'hFFFF, 16'h0001, 8'hFF);
        send_op(ACT_ADC16, 16'h7FFF, 16'h0000, FL_C);
        send_op(ACT_SBC16, 16'h0000, 16'hFFFF, FL_C | FL_53);
        send_op(ACT_UNUSED_HI, 16'hFFFF, 16'hFFFF, 8'hA5);
    endtask

    // Random mix with bubbles on both sides.
    task automatic test_random_idle(input int count);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_random_ops(count);
    endtask

    // Back-to-back stream with no bubbles anywhere.
    task automatic test_random_streaming(input int count);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random_ops(count);
    endtask

    // Hold the output off for a long stretch while input keeps coming.
    task automatic test_output_hold(input int count);
        wait_drained();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        sink_hold    = LONG_HOLD;
        send_random_ops(count);
    endtask

    // Let the pipe run dry between two bursts.
    task automatic test_input_pause(input int count);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_random_ops(count);
        wait_drained();
        send_random_ops(count);
    endtask

    initial begin
        // hold reset at the start
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_byte_ops();
        test_shift_word_ops();
        test_random_idle(450);
        test_random_streaming(250);
        test_output_hold(150);
        test_input_pause(60);
        test_random_idle(130);

        // drop valid, then give the pipe a bounded window to empty
        in_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            log_failure($sformatf("%0d results never arrived", pending_results.size()));

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/c8alu_pkg.sv
rtl/core/c8alu_decode.sv
rtl/core/c8alu_exec.sv
rtl/core/c8alu_flags.sv
rtl/core/cpu8_alu_with_flags_top.sv
tb/sv/tb.sv
